// ===== hdl/ttpq_pkg.sv =====
// ---------------------------------------------------------------------------
// ttpq_pkg: shared types and constants of the timed task priority queue
// Payload structs, operation and status codes, table sizes.
// ---------------------------------------------------------------------------
package ttpq_pkg;

  // Table size and widths derived from it
  localparam int unsigned SLOTS     = 64;
  localparam int unsigned IDX_W     = $clog2(SLOTS);
  localparam int unsigned CNT_W     = $clog2(SLOTS + 1);
  localparam int unsigned TIME_BITS = 48;
  localparam int unsigned SEQ_W     = 32;

  // Operation codes
  typedef enum logic [2:0] {
    OP_PUSH   = 3'd0,
    OP_REMOVE = 3'd1,
    OP_POP    = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_RESET  = 3'd4
  } op_e;

  // Status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_TASK  = 3'd1,
    ST_CANCELED  = 3'd2,
    ST_EXECUTED  = 3'd3,
    ST_SCHEDULED = 3'd4,
    ST_EMPTY     = 3'd5
  } status_e;

  // Request transfer
  typedef struct packed {
    logic [2:0]  operation;
    logic [5:0]  task_slot;
    logic [47:0] due_time;
    logic        time_valid;
    logic        has_action;
  } op_req_t;

  // Result transfer
  typedef struct packed {
    logic [2:0]  status;
    logic        fired_valid;
    logic [5:0]  fired_slot;
    logic [47:0] earliest_time;
    logic        queue_empty;
    logic [6:0]  queued_count;
  } op_rsp_t;

endpackage

// ===== hdl/timed_task_priority_queue.sv =====
// ---------------------------------------------------------------------------
// timed_task_priority_queue: task slot table with earliest-due selection
// Push, remove, pop earliest, clear all and reset slot on a table of task
// slots; every request returns one result with status and queue summary.
// ---------------------------------------------------------------------------
// Each request is applied in the cycle it is accepted, using the earliest
// slot found by the previous request's scan. The block then scans every
// slot once with a single time/sequence comparator, reading one slot per
// cycle from the due-time and sequence memories, to find the new earliest
// task. A request therefore occupies the block through the accept state,
// the S_SCAN reads of every slot, S_DRAIN for the last compare and S_DONE,
// which loads the result register once it is free. in_ready_o is low during
// the scan; a finished result waits in the output register until taken.
// Ordering is by due time, then sequence number, then lowest slot index.
module timed_task_priority_queue
  import ttpq_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  op_req_t in_req_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output op_rsp_t out_rsp_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } state_e;

  state_e state_q;

  // Slot marks, kept in flops
  logic [SLOTS-1:0] sched_q, exec_q, cancel_q, numbered_q;
  logic [CNT_W-1:0] count_q;
  logic [SEQ_W-1:0] seq_cnt_q;

  // Slot memories
  logic [TIME_BITS-1:0] due_mem [SLOTS];
  logic [SEQ_W-1:0]     seq_mem [SLOTS];
  logic [TIME_BITS-1:0] due_rd_q;
  logic [SEQ_W-1:0]     seq_rd_q;

  // Scan pipeline
  logic [IDX_W-1:0]     idx_q, rd_idx_q;
  logic                 rd_vld_q;
  logic                 best_valid_q;
  logic [IDX_W-1:0]     best_idx_q;
  logic [TIME_BITS-1:0] best_time_q;
  logic [SEQ_W-1:0]     best_seq_q;

  // Earliest slot from the last completed scan
  logic                 early_valid_q;
  logic [IDX_W-1:0]     early_idx_q;

  // Per-request result fields
  logic [2:0]           status_q;
  logic                 fired_q;
  logic [IDX_W-1:0]     fired_idx_q;

  logic    out_valid_q;
  op_rsp_t out_q;

  // Request decode
  logic             accept;
  logic             in_range;
  logic [IDX_W-1:0] slot_idx;
  logic             push_ok;
  logic [2:0]       push_status;
  logic [SEQ_W-1:0] seq_next;
  logic [SEQ_W-1:0] cand_seq;
  logic             take;
  logic             load_out;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;
  assign load_out    = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    in_range = (32'(in_req_i.task_slot) < SLOTS);
    slot_idx = IDX_W'(in_req_i.task_slot);
    seq_next = seq_cnt_q + SEQ_W'(1);
    push_ok  = 1'b0;
    priority if (!in_range || !in_req_i.time_valid || !in_req_i.has_action) begin
      push_status = ST_BAD_TASK;
    end else if (cancel_q[slot_idx]) begin
      push_status = ST_CANCELED;
    end else if (exec_q[slot_idx]) begin
      push_status = ST_EXECUTED;
    end else if (sched_q[slot_idx]) begin
      push_status = ST_SCHEDULED;
    end else begin
      push_status = ST_OK;
      push_ok     = 1'b1;
    end
  end

  // Compare the slot read last cycle against the running best
  always_comb begin
    cand_seq = numbered_q[rd_idx_q] ? seq_rd_q : '0;
    take = rd_vld_q && sched_q[rd_idx_q] &&
           (!best_valid_q || (due_rd_q < best_time_q) ||
            ((due_rd_q == best_time_q) && (cand_seq < best_seq_q)));
  end

  // Slot memories: write on push, read the scan address every cycle
  always_ff @(posedge clk_i) begin
    due_rd_q <= due_mem[idx_q];
    seq_rd_q <= seq_mem[idx_q];
    if (accept && (in_req_i.operation == OP_PUSH) && push_ok) begin
      due_mem[slot_idx] <= in_req_i.due_time;
      if (!numbered_q[slot_idx]) begin
        seq_mem[slot_idx] <= seq_next;
      end
    end
  end

  // Sequencer, slot marks and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      sched_q       <= '0;
      exec_q        <= '0;
      cancel_q      <= '0;
      numbered_q    <= '0;
      count_q       <= '0;
      seq_cnt_q     <= '0;
      idx_q         <= '0;
      rd_idx_q      <= '0;
      rd_vld_q      <= 1'b0;
      best_valid_q  <= 1'b0;
      best_idx_q    <= '0;
      best_time_q   <= '0;
      best_seq_q    <= '0;
      early_valid_q <= 1'b0;
      early_idx_q   <= '0;
      status_q      <= ST_OK;
      fired_q       <= 1'b0;
      fired_idx_q   <= '0;
      out_valid_q   <= 1'b0;
      out_q         <= '0;
    end else begin
      // Advance the read pipeline
      rd_vld_q <= (state_q == S_SCAN);
      rd_idx_q <= idx_q;
      if (take) begin
        best_valid_q <= 1'b1;
        best_idx_q   <= rd_idx_q;
        best_time_q  <= due_rd_q;
        best_seq_q   <= cand_seq;
      end

      // Drop the result once transferred
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q      <= S_SCAN;
            idx_q        <= '0;
            best_valid_q <= 1'b0;
            status_q     <= ST_OK;
            fired_q      <= 1'b0;
            fired_idx_q  <= '0;
            unique case (in_req_i.operation)
              OP_PUSH: begin
                status_q <= push_status;
                if (push_ok) begin
                  sched_q[slot_idx] <= 1'b1;
                  count_q           <= count_q + CNT_W'(1);
                  if (!numbered_q[slot_idx]) begin
                    seq_cnt_q            <= seq_next;
                    numbered_q[slot_idx] <= (seq_next != '0);
                  end
                end
              end
              OP_REMOVE: begin
                if (in_range && sched_q[slot_idx]) begin
                  sched_q[slot_idx]  <= 1'b0;
                  cancel_q[slot_idx] <= 1'b1;
                  count_q            <= count_q - CNT_W'(1);
                end
              end
              OP_POP: begin
                if (early_valid_q) begin
                  sched_q[early_idx_q] <= 1'b0;
                  exec_q[early_idx_q]  <= 1'b1;
                  count_q              <= count_q - CNT_W'(1);
                  fired_q              <= 1'b1;
                  fired_idx_q          <= early_idx_q;
                end else begin
                  status_q <= ST_EMPTY;
                end
              end
              OP_CLEAR: begin
                cancel_q <= cancel_q | sched_q;
                sched_q  <= '0;
                count_q  <= '0;
              end
              OP_RESET: begin
                if (in_range) begin
                  if (sched_q[slot_idx]) begin
                    count_q <= count_q - CNT_W'(1);
                  end
                  sched_q[slot_idx]  <= 1'b0;
                  exec_q[slot_idx]   <= 1'b0;
                  cancel_q[slot_idx] <= 1'b0;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_SCAN: begin
          if (idx_q == IDX_W'(SLOTS - 1)) begin
            state_q <= S_DRAIN;
          end else begin
            idx_q <= idx_q + IDX_W'(1);
          end
        end
        S_DRAIN: begin
          state_q <= S_DONE;
        end
        S_DONE: begin
          // Hold until the output register is free
          if (load_out) begin
            state_q                 <= S_IDLE;
            early_valid_q           <= best_valid_q;
            early_idx_q             <= best_idx_q;
            out_valid_q             <= 1'b1;
            out_q.status            <= status_q;
            out_q.fired_valid       <= fired_q;
            out_q.fired_slot        <= 6'(fired_idx_q);
            out_q.earliest_time     <= best_valid_q ? 48'(best_time_q) : '1;
            out_q.queue_empty       <= (count_q == '0);
            out_q.queued_count      <= 7'(count_q);
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== bench/tb_timed_task_priority_queue.sv =====
// ---------------------------------------------------------------------------
// tb_timed_task_priority_queue: self-checking bench of the timed task queue
// Drives push, remove, pop, clear, reset-slot and unused operation codes,
// predicts every result from a private copy of the slot table, and compares
// each result field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module tb_timed_task_priority_queue;
  import ttpq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Run length and limits; phase boundaries are counted in accepted requests
  localparam int RANDOM_OPS   = 800;
  localparam int PHASE1_START = 300;
  localparam int PHASE2_START = 560;
  localparam int HOLD_CYCLES  = 600;
  localparam int CYCLE_LIMIT  = 500_000;
  localparam logic [47:0] NO_TIME = '1;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    req_valid;
  logic    req_ready;
  op_req_t req_data;
  logic    rsp_valid;
  logic    rsp_ready;
  op_rsp_t rsp_data;

  // Requests waiting to be offered, and results predicted for accepted ones
  op_req_t pending_ops[$];
  op_rsp_t predicted_results[$];
  op_rsp_t want;
  int      accepted_count = 0;
  int      total_ops = 0;
  int      error_count = 0;
  int      cycle_count = 0;
  int      hold_left = 0;
  bit      pressure_done = 1'b0;

  // Model of the slot table
  logic [TIME_BITS-1:0] due_tbl[SLOTS];
  logic [SEQ_W-1:0]     seq_tbl[SLOTS];
  bit                   sched_tbl[SLOTS];
  bit                   done_tbl[SLOTS];
  bit                   cancel_tbl[SLOTS];
  logic [SEQ_W-1:0]     seq_counter;

  timed_task_priority_queue dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_valid),
    .in_ready_o (req_ready),
    .in_req_i   (req_data),
    .out_valid_o(rsp_valid),
    .out_ready_i(rsp_ready),
    .out_rsp_o  (rsp_data)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Earliest scheduled slot by due time, then sequence, then lowest index
  function automatic int earliest_slot();
    int best;
    best = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (sched_tbl[i] && (best < 0 || due_tbl[i] < due_tbl[best] ||
          (due_tbl[i] == due_tbl[best] && seq_tbl[i] < seq_tbl[best])))
        best = i;
    end
    return best;
  endfunction

  // Apply one request to the table model and return the result it yields
  function automatic op_rsp_t apply_queue_op(op_req_t req);
    op_rsp_t rsp;
    int      s;
    int      e;
    int      n;
    bit      in_range;
    rsp      = '0;
    in_range = req.task_slot < SLOTS;
    s        = in_range ? int'(req.task_slot) : 0;
    case (req.operation)
      OP_PUSH: begin
        if (!in_range || !req.time_valid || !req.has_action) rsp.status = ST_BAD_TASK;
        else if (cancel_tbl[s]) rsp.status = ST_CANCELED;
        else if (done_tbl[s]) rsp.status = ST_EXECUTED;
        else if (sched_tbl[s]) rsp.status = ST_SCHEDULED;
        else begin
          sched_tbl[s] = 1'b1;
          due_tbl[s]   = req.due_time;
          // number the slot on its first push; a wrapped zero stays unnumbered
          if (seq_tbl[s] == '0) begin
            seq_counter = seq_counter + SEQ_W'(1);
            seq_tbl[s]  = seq_counter;
          end
        end
      end
      OP_REMOVE: begin
        if (in_range && sched_tbl[s]) begin
          sched_tbl[s]  = 1'b0;
          cancel_tbl[s] = 1'b1;
        end
      end
      OP_POP: begin
        e = earliest_slot();
        if (e < 0) rsp.status = ST_EMPTY;
        else begin
          sched_tbl[e]    = 1'b0;
          done_tbl[e]     = 1'b1;
          rsp.fired_valid = 1'b1;
          rsp.fired_slot  = e[5:0];
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (sched_tbl[i]) begin
            sched_tbl[i]  = 1'b0;
            cancel_tbl[i] = 1'b1;
          end
        end
      end
      OP_RESET: begin
        // free the slot but keep its sequence number
        if (in_range) begin
          sched_tbl[s]  = 1'b0;
          done_tbl[s]   = 1'b0;
          cancel_tbl[s] = 1'b0;
          due_tbl[s]    = NO_TIME;
        end
      end
      default: ;
    endcase
    n = 0;
    for (int i = 0; i < SLOTS; i++) if (sched_tbl[i]) n++;
    e = earliest_slot();
    rsp.earliest_time = (e < 0) ? NO_TIME : due_tbl[e];
    rsp.queue_empty   = (n == 0);
    rsp.queued_count  = n[6:0];
    return rsp;
  endfunction

  function automatic op_req_t make_req(logic [2:0] op, int slot, logic [47:0] due,
                                       bit tvalid, bit action);
    op_req_t r;
    r.operation  = op;
    r.task_slot  = slot[5:0];
    r.due_time   = due;
    r.time_valid = tvalid;
    r.has_action = action;
    return r;
  endfunction

  function automatic logic [47:0] random_due();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return NO_TIME;
      2, 3:    return 48'($urandom_range(0, 15));
      default: return {16'($urandom()), 32'($urandom())};
    endcase
  endfunction

  // Append one random operation; pushes often come right after a slot reset
  task automatic add_random_op();
    int          pick;
    int          slot;
    logic [47:0] due;
    pick = $urandom_range(0, 99);
    slot = $urandom_range(0, SLOTS - 1);
    due  = random_due();
    if (pick < 45) begin
      if ($urandom_range(0, 1) == 1)
        pending_ops.push_back(make_req(OP_RESET, slot, random_due(), 1'($urandom()),
                                       1'($urandom())));
      pending_ops.push_back(make_req(OP_PUSH, slot, due, $urandom_range(0, 19) != 0,
                                     $urandom_range(0, 19) != 0));
    end else if (pick < 55) begin
      pending_ops.push_back(make_req(OP_RESET, slot, due, 1'($urandom()), 1'($urandom())));
    end else if (pick < 80) begin
      pending_ops.push_back(make_req(OP_POP, slot, due, 1'($urandom()), 1'($urandom())));
    end else if (pick < 92) begin
      pending_ops.push_back(make_req(OP_REMOVE, slot, due, 1'($urandom()), 1'($urandom())));
    end else if (pick < 96) begin
      pending_ops.push_back(make_req(OP_CLEAR, slot, due, 1'($urandom()), 1'($urandom())));
    end else begin
      pending_ops.push_back(make_req(3'($urandom_range(OP_RESET + 1, 7)), slot, due,
                                     1'($urandom()), 1'($urandom())));
    end
  endtask

  function automatic int sender_idle_pct();
    if (accepted_count < PHASE1_START) return 32;
    if (accepted_count < PHASE2_START) return 85;
    return 0;
  endfunction

  function automatic int receiver_idle_pct();
    if (accepted_count < PHASE1_START) return 85;
    if (accepted_count < PHASE2_START) return 32;
    return 0;
  endfunction

  task automatic check_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
      error_count++;
    end
  endtask

  // Offer pending requests; predict each result on transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid <= 1'b0;
      req_data  <= '0;
    end else begin
      if (req_valid && req_ready) begin
        predicted_results.push_back(apply_queue_op(req_data));
        accepted_count <= accepted_count + 1;
      end
      if (!req_valid || req_ready) begin
        if (pending_ops.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
          req_valid <= 1'b1;
          req_data  <= pending_ops.pop_front();
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Take results, compare with predictions, stall at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (predicted_results.size() == 0) begin
          $error("result transfer with no request outstanding");
          error_count++;
        end else begin
          want = predicted_results.pop_front();
          check_field("status", 64'(want.status), 64'(rsp_data.status));
          check_field("fired_valid", 64'(want.fired_valid), 64'(rsp_data.fired_valid));
          check_field("fired_slot", 64'(want.fired_slot), 64'(rsp_data.fired_slot));
          check_field("earliest_time", 64'(want.earliest_time),
                      64'(rsp_data.earliest_time));
          check_field("queue_empty", 64'(want.queue_empty), 64'(rsp_data.queue_empty));
          check_field("queued_count", 64'(want.queued_count), 64'(rsp_data.queued_count));
        end
      end
      // hold off once for a long stretch so the block backs up its input
      if (accepted_count >= PHASE2_START && !pressure_done) begin
        pressure_done = 1'b1;
        hold_left     = HOLD_CYCLES;
        rsp_ready    <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left  = hold_left - 1;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= $urandom_range(0, 99) >= receiver_idle_pct();
      end
    end
  end

  // Abort a hung run
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      due_tbl[i]    = '0;
      seq_tbl[i]    = '0;
      sched_tbl[i]  = 1'b0;
      done_tbl[i]   = 1'b0;
      cancel_tbl[i] = 1'b0;
    end
    seq_counter = '0;

    // Directed: empty pop, bad tasks, duplicates, ties, cancel and reuse
    pending_ops.push_back(make_req(OP_POP, 0, '0, 1'b0, 1'b0));
    pending_ops.push_back(make_req(OP_PUSH, 0, '0, 1'b1, 1'b1));
    pending_ops.push_back(make_req(OP_PUSH, SLOTS - 1, NO_TIME, 1'b1, 1'b1));
    pending_ops.push_back(make_req(OP_PUSH, 0, 48'd5, 1'b1, 1'b1));
    pending_ops.push_back(make_req(OP_PUSH, 5, 48'd7, 1'b0, 1'b1));
    pending_ops.push_back(make_req(OP_PUSH, 5, 48'd7, 1'b1, 1'b0));
    pending_ops.push_back(make_req(OP_PUSH, 40, 48'd7, 1'b1, 1'b1));
    pending_ops.push_back(make_req(OP_PUSH, 2, 48'd7, 1'b1, 1'b1));
    pending_ops.push_back(make_req(OP_PUSH, 10, '0, 1'b1, 1'b1));
    pending_ops.push_back(make_req(OP_POP, 0, '0, 1'b1, 1'b1));
    pending_ops.push_back(make_req(OP_PUSH, 0, '0, 1'b1, 1'b1));
    pending_ops.push_back(make_req(OP_REMOVE, 10, '0, 1'b1, 1'b1));
    pending_ops.push_back(make_req(OP_PUSH, 10, '0, 1'b1, 1'b1));
    pending_ops.push_back(make_req(OP_REMOVE, 20, '0, 1'b1, 1'b1));
    pending_ops.push_back(make_req(OP_POP, 0, '0, 1'b1, 1'b1));
    pending_ops.push_back(make_req(OP_RESET, 10, '0, 1'b1, 1'b1));
    pending_ops.push_back(make_req(OP_PUSH, 10, 48'h8000_0000_0001, 1'b1, 1'b1));
    pending_ops.push_back(make_req(OP_RESET, SLOTS - 1, '0, 1'b0, 1'b0));
    for (int c = OP_RESET + 1; c < 8; c++)
      pending_ops.push_back(make_req(3'(c), 2, NO_TIME, 1'b1, 1'b1));
    pending_ops.push_back(make_req(OP_CLEAR, 0, '0, 1'b1, 1'b1));
    pending_ops.push_back(make_req(OP_POP, 0, '0, 1'b1, 1'b1));
    pending_ops.push_back(make_req(OP_RESET, 0, '0, 1'b1, 1'b1));
    pending_ops.push_back(make_req(OP_PUSH, 0, 48'h5A5A_A5A5_3C3C, 1'b1, 1'b1));
    pending_ops.push_back(make_req(OP_POP, 0, '0, 1'b1, 1'b1));

    total_ops = pending_ops.size() + RANDOM_OPS;
    while (pending_ops.size() < total_ops) add_random_op();
    total_ops = pending_ops.size();

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain: every request taken, every result checked, then settle
    while (accepted_count != total_ops || predicted_results.size() != 0) @(posedge clk_i);
    repeat (SLOTS + 8) @(posedge clk_i);

    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/ttpq_pkg.sv
hdl/timed_task_priority_queue.sv
bench/tb_timed_task_priority_queue.sv
